// ----- rtl/core/hrp_pkg.sv -----
// Shared types and codes for the HTTP request byte parser.
// No dependencies; imported by every module of the block.
package hrp_pkg;

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_PATH    = 3'd1,
		PH_QUERY   = 3'd2,
		PH_VERSION = 3'd3,
		PH_NAME    = 3'd4,
		PH_VALUE   = 3'd5,
		PH_BODY    = 3'd6,
		PH_BAD     = 3'd7
	} phase_t;

	localparam logic [3:0] ROLE_METHOD  = 4'd0;
	localparam logic [3:0] ROLE_PATH    = 4'd1;
	localparam logic [3:0] ROLE_QUERY   = 4'd2;
	localparam logic [3:0] ROLE_VERSION = 4'd3;
	localparam logic [3:0] ROLE_NAME    = 4'd4;
	localparam logic [3:0] ROLE_VALUE   = 4'd5;
	localparam logic [3:0] ROLE_BODY    = 4'd6;
	localparam logic [3:0] ROLE_DELIM   = 4'd7;
	localparam logic [3:0] ROLE_EXCESS  = 4'd8;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_LINE_INC   = 3'd1;
	localparam logic [2:0] ST_LINE_BAD   = 3'd2;
	localparam logic [2:0] ST_BODY_SHORT = 3'd3;
	localparam logic [2:0] ST_HDR_UNTERM = 3'd4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// one tagged byte as it travels through the queue
	typedef struct packed {
		logic [7:0]  data;
		logic [3:0]  role;
		logic        first;
		logic        drop;
		logic        fin;
		logic [2:0]  status;
		logic        ka;
		logic [31:0] cl;
		logic [31:0] bl;
	} res_t;

endpackage

// ----- rtl/core/hrp_front.sv -----
// Front end: parse state and byte classification, up to two results per byte.
// Depends on hrp_pkg.
module hrp_front import hrp_pkg::*; #(
	parameter int LENGTH_VALUE_MAX_BYTES = 31,
	parameter int COUNTER_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       room2,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       in_ready,
	output logic [1:0] push_n,
	output res_t       push_r0,
	output res_t       push_r1
);

	typedef struct packed {
		phase_t                  phase;
		logic                    held_cr;
		logic [15:0]             fc;
		logic [1:0]              nmf;
		logic                    cm;
		logic                    vs;
		logic [31:0]             acc;
		logic                    neg;
		logic [31:0]             lval;
		logic                    ka;
		logic [COUNTER_BITS-1:0] bc;
		logic                    qs;
		logic [1:0]              np;
	} fst_t;

	localparam fst_t ST_RST = '{phase: PH_METHOD, held_cr: 1'b0, fc: 16'd0, nmf: 2'b11,
		cm: 1'b1, vs: 1'b0, acc: 32'd0, neg: 1'b0, lval: 32'hFFFF_FFFF, ka: 1'b1,
		bc: '0, qs: 1'b0, np: 2'd0};

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] cl_char(input logic [3:0] i);
		case (i)
			4'd0: return "c";
			4'd1: return "o";
			4'd2: return "n";
			4'd3: return "t";
			4'd4: return "e";
			4'd5: return "n";
			4'd6: return "t";
			4'd7: return "-";
			4'd8: return "l";
			4'd9: return "e";
			4'd10: return "n";
			4'd11: return "g";
			4'd12: return "t";
			4'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] conn_char(input logic [3:0] i);
		case (i)
			4'd0: return "c";
			4'd1: return "o";
			4'd2: return "n";
			4'd3: return "n";
			4'd4: return "e";
			4'd5: return "c";
			4'd6: return "t";
			4'd7: return "i";
			4'd8: return "o";
			4'd9: return "n";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input logic [2:0] i);
		case (i)
			3'd0: return "c";
			3'd1: return "l";
			3'd2: return "o";
			3'd3: return "s";
			3'd4: return "e";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [31:0] sat_bc(input logic [COUNTER_BITS-1:0] bc);
		logic [63:0] w;
		w = 64'(bc);
		return (|w[63:32]) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	function automatic res_t base_res(input fst_t s, input logic [7:0] b);
		res_t r;
		r.data = b; r.role = ROLE_DELIM; r.first = 1'b0; r.drop = 1'b0; r.fin = 1'b0;
		r.status = ST_OK; r.ka = s.ka; r.cl = s.lval; r.bl = sat_bc(s.bc);
		return r;
	endfunction

	function automatic void classify(input fst_t s, input logic [7:0] b,
			output fst_t ns, output res_t r);
		logic [7:0]  lb;
		logic        dat;
		logic        pos;
		logic        is_body;
		logic        digit;
		logic        space;
		logic [35:0] m;
		ns = s;
		lb = lower(b);
		dat = 1'b0;
		r = base_res(s, b);
		digit = b >= CH_ZERO && b <= CH_NINE;
		space = b == CH_SP || (b >= 8'd9 && b <= 8'd13);
		case (s.phase)
			PH_METHOD: begin
				if (b == CH_SP) begin
					ns.phase = PH_PATH; ns.fc = '0;
				end else begin
					dat = 1'b1; r.role = ROLE_METHOD;
				end
			end
			PH_PATH, PH_QUERY: begin
				if (b == CH_SP) begin
					ns.phase = PH_VERSION; ns.fc = '0;
				end else if (s.phase == PH_PATH && b == CH_QMARK && !s.qs) begin
					ns.qs = 1'b1; ns.phase = PH_QUERY; ns.fc = '0;
				end else begin
					dat = 1'b1; r.role = {1'b0, s.phase};
				end
			end
			PH_VERSION: begin
				dat = 1'b1; r.role = ROLE_VERSION;
			end
			PH_NAME: begin
				if (b == CH_COLON) begin
					ns.nmf = {s.nmf[1] && s.fc == 16'd10, s.nmf[0] && s.fc == 16'd14};
					ns.phase = PH_VALUE; ns.fc = '0; ns.vs = 1'b0; ns.cm = 1'b1;
					ns.acc = '0; ns.neg = 1'b0; ns.np = 2'd0;
				end else begin
					if (s.fc >= 16'd14 || lb != cl_char(s.fc[3:0])) ns.nmf[0] = 1'b0;
					if (s.fc >= 16'd10 || lb != conn_char(s.fc[3:0])) ns.nmf[1] = 1'b0;
					dat = 1'b1; r.role = ROLE_NAME;
				end
			end
			PH_VALUE: begin
				if (!(!s.vs && (b == CH_SP || b == CH_TAB))) begin
					ns.vs = 1'b1;
					if (s.fc >= 16'd5 || lb != close_char(s.fc[2:0])) ns.cm = 1'b0;
					// strtol-style scan: blanks, sign, digits, then stop
					if (s.np == 2'd0 && space) begin
						ns.np = s.np;
					end else if (s.np == 2'd0 && (b == CH_PLUS || b == CH_MINUS)) begin
						ns.neg = b == CH_MINUS; ns.np = 2'd1;
					end else if (s.np != 2'd3 && digit) begin
						m = {s.acc, 3'b000} + {2'b00, s.acc, 1'b0} + 36'(b - CH_ZERO);
						ns.acc = (m > 36'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
						ns.np = 2'd2;
					end else begin
						ns.np = 2'd3;
					end
					dat = 1'b1; r.role = ROLE_VALUE;
				end
			end
			PH_BODY: begin
				pos = !s.lval[31] && s.lval != 32'd0;
				is_body = pos ? (64'(s.bc) < {32'd0, s.lval})
					: (s.lval[31] && s.lval != 32'hFFFF_FFFF);
				if (is_body) begin
					r.role = ROLE_BODY; r.first = s.bc == '0;
					if (s.bc != '1) ns.bc = s.bc + 1'b1;
				end else begin
					r.role = ROLE_EXCESS;
				end
			end
			default: r.role = ROLE_EXCESS;
		endcase
		if (dat) begin
			r.first = s.fc == '0;
			if (s.fc != 16'hFFFF) ns.fc = s.fc + 16'd1;
		end
	endfunction

	function automatic void close_line(input fst_t s, output fst_t ns,
			output res_t ra, output res_t rb);
		logic drop;
		ns = s;
		drop = 1'b0;
		if (s.phase <= PH_VERSION) begin
			if (s.phase == PH_VERSION && s.fc >= 16'd6) begin
				ns.phase = PH_NAME; ns.fc = '0; ns.nmf = 2'b11;
			end else begin
				ns.phase = PH_BAD;
			end
		end else if (s.phase == PH_NAME) begin
			if (s.fc == '0) begin
				ns.phase = PH_BODY;
			end else begin
				drop = 1'b1; ns.fc = '0; ns.nmf = 2'b11;
			end
		end else begin
			if (s.nmf[0] && s.fc <= 16'(LENGTH_VALUE_MAX_BYTES)) begin
				if (s.neg) ns.lval = 32'd0 - s.acc;
				else ns.lval = s.acc[31] ? 32'h7FFF_FFFF : s.acc;
			end
			if (s.nmf[1] && s.fc == 16'd5 && s.cm) ns.ka = 1'b0;
			ns.phase = PH_NAME; ns.fc = '0; ns.nmf = 2'b11;
		end
		ra = base_res(ns, CH_CR);
		rb = base_res(ns, CH_LF);
		rb.drop = drop;
	endfunction

	fst_t       st_q;
	fst_t       nxt;
	logic [1:0] n;
	logic       accept;

	assign in_ready = room2;
	assign accept   = in_valid && room2;

	always_comb begin
		fst_t       s1;
		fst_t       s2;
		res_t       ra;
		res_t       rb;
		logic       lf;
		logic [2:0] st;
		s1 = st_q;
		s2 = st_q;
		ra = base_res(st_q, data_byte);
		rb = ra;
		push_r0 = ra;
		push_r1 = ra;
		n = 2'd0;
		lf = 1'b0;
		st = ST_OK;
		// a held CR resolves now: line end on LF, else a plain byte
		if (st_q.held_cr) begin
			s1.held_cr = 1'b0;
			if (data_byte == CH_LF) begin
				close_line(s1, s2, ra, rb);
				s1 = s2; push_r0 = ra; push_r1 = rb; n = 2'd2; lf = 1'b1;
			end else begin
				classify(s1, CH_CR, s2, ra);
				s1 = s2; push_r0 = ra; n = 2'd1;
			end
		end
		if (!lf) begin
			if (data_byte == CH_CR && !last_byte && s1.phase <= PH_VALUE) begin
				s1.held_cr = 1'b1;
			end else begin
				classify(s1, data_byte, s2, ra);
				s1 = s2;
				if (n == 2'd0) push_r0 = ra;
				else push_r1 = ra;
				n = n + 2'd1;
			end
		end
		if (last_byte) begin
			if (s1.phase <= PH_VERSION) st = ST_LINE_INC;
			else if (s1.phase == PH_BAD) st = ST_LINE_BAD;
			else if (s1.phase != PH_BODY) st = ST_HDR_UNTERM;
			else if (!s1.lval[31] && s1.lval != 32'd0 && 64'(s1.bc) < {32'd0, s1.lval})
				st = ST_BODY_SHORT;
			else st = ST_OK;
			if (n == 2'd2) begin
				push_r1.fin = 1'b1; push_r1.status = st;
			end else begin
				push_r0.fin = 1'b1; push_r0.status = st;
			end
			s1 = ST_RST;
		end
		nxt = s1;
	end

	assign push_n = accept ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RST;
		end else if (accept) begin
			st_q <= nxt;
		end
	end

endmodule

// ----- rtl/core/hrp_fifo.sv -----
// Four-entry result queue: up to two pushes and one pop per cycle.
// Depends on hrp_pkg.
module hrp_fifo import hrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  res_t       push_r0,
	input  res_t       push_r1,
	input  logic       pop,
	output logic       room2,
	output logic       not_empty,
	output logic [2:0] count,
	output res_t       head
);

	res_t       mem [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;

	assign room2     = cnt_q <= 3'd2;
	assign not_empty = cnt_q != 3'd0;
	assign count     = cnt_q;
	assign head      = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem[wp_q] <= push_r0;
		if (push_n == 2'd2) mem[wp_q + 2'd1] <= push_r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + push_n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

endmodule

// ----- rtl/core/http_request_byte_parser.sv -----
// HTTP request byte parser, top level: front parser, result queue, output ports.
// Results are registered in the queue before they appear (a CR waits for the next byte).
// Throughput: one byte per cycle while in_ready is high; a byte may yield two results
//   (CR LF pair, or a released CR plus the new byte), drained one per cycle while out_ready
//   is high from the 4-entry queue. Input ready drops while the queue holds over two results.
// Reset (arst_n low, asynchronous) empties the queue and returns the parser to the method field.
module http_request_byte_parser import hrp_pkg::*; #(
	parameter int LENGTH_VALUE_MAX_BYTES = 31,
	parameter int COUNTER_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic [3:0]         role,
	output logic               field_first,
	output logic               drop_line,
	output logic               final_res,
	output logic [2:0]         status,
	output logic               conn_persist,
	output logic signed [31:0] req_length,
	output logic [31:0]        body_length
);

	logic       room2;
	logic [1:0] push_n;
	res_t       push_r0;
	res_t       push_r1;
	logic       pop;
	logic [2:0] count;
	res_t       head;

	// front: classifies each beat, may produce up to two results
	hrp_front #(
		.LENGTH_VALUE_MAX_BYTES(LENGTH_VALUE_MAX_BYTES),
		.COUNTER_BITS(COUNTER_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.room2(room2),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.in_ready(in_ready),
		.push_n(push_n),
		.push_r0(push_r0),
		.push_r1(push_r1)
	);

	// back: queue head drives the output channel directly
	hrp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.push_r0(push_r0),
		.push_r1(push_r1),
		.pop(pop),
		.room2(room2),
		.not_empty(out_valid),
		.count(count),
		.head(head)
	);

	assign pop          = out_valid && out_ready;
	assign out_byte     = head.data;
	assign role         = head.role;
	assign field_first  = head.first;
	assign drop_line    = head.drop;
	assign final_res    = head.fin;
	assign status       = head.status;
	assign conn_persist = head.ka;
	assign req_length   = $signed(head.cl);
	assign body_length  = head.bl;

	// queue occupancy tracks pushes and pops exactly
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count == $past(count) + {1'b0, $past(push_n)} - {2'b00, $past(pop)})
		else $error("queue count mismatch");

	// never overfill
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> count <= 3'd2)
		else $error("queue overfill");

	// status is only carried by the closing result
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_res |-> status == ST_OK)
		else $error("status on non-final result");

	// delimiters never open a field
	a_delim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (role == ROLE_DELIM || role == ROLE_EXCESS) |-> !field_first)
		else $error("field_first on delimiter");

endmodule

// ----- dv/http_request_byte_parser_checker.sv -----
// Checker for the HTTP request byte parser: watches both channels, predicts the
// tagged bytes of every accepted input beat and compares them in order.
// Depends on hrp_pkg for the result record, role, status and phase codes.
module http_request_byte_parser_checker import hrp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         out_byte,
	input  logic [3:0]         role,
	input  logic               field_first,
	input  logic               drop_line,
	input  logic               final_res,
	input  logic [2:0]         status,
	input  logic               conn_persist,
	input  logic signed [31:0] req_length,
	input  logic [31:0]        body_length,
	output int                 errors,
	output int                 pending
);

	localparam int VALUE_MAX = 31;

	res_t      tagged_q[$];
	res_t      beat_res[$];
	phase_t    ph;
	bit        cr_held, q_seen, v_started, close_ok, neg, ka_flag;
	bit [15:0] fcnt;
	bit [1:0]  name_ok, num_ph;
	bit [31:0] accum, clen, bcnt;
	string     cl_word = "content-length";
	string     conn_word = "connection";
	string     close_word = "close";

	function automatic bit [7:0] lower(bit [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void clear_parse();
		ph = PH_METHOD; cr_held = 0; fcnt = 0; name_ok = 2'b11; close_ok = 1;
		v_started = 0; accum = 0; neg = 0; clen = '1; ka_flag = 1; bcnt = 0;
		q_seen = 0; num_ph = 0;
	endfunction

	function automatic void tag(bit [7:0] b, logic [3:0] r, bit first, bit drop);
		res_t t;
		if (beat_res.size() >= 2)
			return;
		t = '0;
		t.data = b; t.role = r; t.first = first; t.drop = drop;
		t.ka = ka_flag; t.cl = clen; t.bl = bcnt;
		beat_res.push_back(t);
	endfunction

	function automatic void tag_field(bit [7:0] b, logic [3:0] r);
		tag(b, r, fcnt == 0, 0);
		if (fcnt != 16'hFFFF)
			fcnt++;
	endfunction

	function automatic void start_header_line();
		ph = PH_NAME; fcnt = 0; name_ok = 2'b11;
	endfunction

	function automatic void scan_number(bit [7:0] b);
		bit digit, blank;
		bit [63:0] m;
		digit = b >= CH_ZERO && b <= CH_NINE;
		blank = b == CH_SP || (b >= 8'd9 && b <= 8'd13);
		if (num_ph == 0 && blank)
			return;
		if (num_ph == 0 && (b == CH_PLUS || b == CH_MINUS)) begin
			neg = b == CH_MINUS; num_ph = 1;
			return;
		end
		if (num_ph < 3 && digit) begin
			m = 64'(accum) * 10 + 64'(b - CH_ZERO);
			accum = m > 64'h8000_0000 ? 32'h8000_0000 : m[31:0];
			num_ph = 2;
			return;
		end
		num_ph = 3;
	endfunction

	function automatic void classify(bit [7:0] b);
		longint cl;
		bit is_body;
		case (ph)
			PH_METHOD: begin
				if (b == CH_SP) begin
					ph = PH_PATH; fcnt = 0; tag(b, ROLE_DELIM, 0, 0);
				end else
					tag_field(b, ROLE_METHOD);
			end
			PH_PATH, PH_QUERY: begin
				if (b == CH_SP) begin
					ph = PH_VERSION; fcnt = 0; tag(b, ROLE_DELIM, 0, 0);
				end else if (ph == PH_PATH && b == CH_QMARK && !q_seen) begin
					q_seen = 1; ph = PH_QUERY; fcnt = 0; tag(b, ROLE_DELIM, 0, 0);
				end else
					tag_field(b, ph == PH_PATH ? ROLE_PATH : ROLE_QUERY);
			end
			PH_VERSION: tag_field(b, ROLE_VERSION);
			PH_NAME: begin
				if (b == CH_COLON) begin
					name_ok = {name_ok[1] && fcnt == 10, name_ok[0] && fcnt == 14};
					ph = PH_VALUE; fcnt = 0; v_started = 0; close_ok = 1;
					accum = 0; neg = 0; num_ph = 0;
					tag(b, ROLE_DELIM, 0, 0);
				end else begin
					if (fcnt >= 14 || lower(b) != cl_word[fcnt])
						name_ok[0] = 0;
					if (fcnt >= 10 || lower(b) != conn_word[fcnt])
						name_ok[1] = 0;
					tag_field(b, ROLE_NAME);
				end
			end
			PH_VALUE: begin
				if (!v_started && (b == CH_SP || b == CH_TAB))
					tag(b, ROLE_DELIM, 0, 0);
				else begin
					v_started = 1;
					if (fcnt >= 5 || lower(b) != close_word[fcnt])
						close_ok = 0;
					scan_number(b);
					tag_field(b, ROLE_VALUE);
				end
			end
			PH_BODY: begin
				cl = longint'($signed(clen));
				is_body = cl > 0 ? longint'(bcnt) < cl : cl < -1;
				if (is_body) begin
					tag(b, ROLE_BODY, bcnt == 0, 0);
					if (bcnt != '1)
						bcnt++;
				end else
					tag(b, ROLE_EXCESS, 0, 0);
			end
			default: tag(b, ROLE_EXCESS, 0, 0);
		endcase
	endfunction

	function automatic void end_line();
		bit drop;
		drop = 0;
		if (ph <= PH_VERSION) begin
			if (ph == PH_VERSION && fcnt >= 6)
				start_header_line();
			else
				ph = PH_BAD;
		end else if (ph == PH_NAME) begin
			if (fcnt == 0)
				ph = PH_BODY;
			else begin
				drop = 1; start_header_line();
			end
		end else begin
			if (name_ok[0] && fcnt <= VALUE_MAX)
				clen = neg ? 32'd0 - accum : (accum > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : accum);
			if (name_ok[1] && fcnt == 5 && close_ok)
				ka_flag = 0;
			start_header_line();
		end
		tag(CH_CR, ROLE_DELIM, 0, 0);
		tag(CH_LF, ROLE_DELIM, 0, drop);
	endfunction

	// whole effect of one accepted input beat
	function automatic void parse_beat(bit [7:0] b, bit fin);
		res_t t;
		logic [2:0] st;
		beat_res.delete();
		if (cr_held && b == CH_LF) begin
			cr_held = 0;
			end_line();
		end else begin
			if (cr_held) begin
				cr_held = 0;
				classify(CH_CR);
			end
			if (b == CH_CR && !fin && ph <= PH_VALUE)
				cr_held = 1;
			else
				classify(b);
		end
		if (fin && beat_res.size() > 0) begin
			if (ph <= PH_VERSION)
				st = ST_LINE_INC;
			else if (ph == PH_BAD)
				st = ST_LINE_BAD;
			else if (ph != PH_BODY)
				st = ST_HDR_UNTERM;
			else if ($signed(clen) > 0 && bcnt < clen)
				st = ST_BODY_SHORT;
			else
				st = ST_OK;
			t = beat_res.pop_back();
			t.fin = 1; t.status = st;
			beat_res.push_back(t);
			clear_parse();
		end
		foreach (beat_res[i])
			tagged_q.push_back(beat_res[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t seen, want;
		if (!arst_n) begin
			clear_parse();
			tagged_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				parse_beat(data_byte, last_byte);
			if (out_valid && out_ready) begin
				seen = '0;
				seen.data = out_byte; seen.role = role; seen.first = field_first;
				seen.drop = drop_line; seen.fin = final_res; seen.status = status;
				seen.ka = conn_persist; seen.cl = req_length; seen.bl = body_length;
				if (tagged_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected beat: %p", seen);
					errors <= errors + 1;
				end else begin
					want = tagged_q.pop_front();
					if (seen !== want) begin
						if (errors < 10)
							$display("mismatch: expected %p, got %p", want, seen);
						errors <= errors + 1;
					end
				end
			end
			pending <= tagged_q.size();
		end
	end

endmodule

// ----- dv/tb_http_request_byte_parser.sv -----
// Testbench top for the HTTP request byte parser: builds request byte streams
// (well-formed, truncated, noise), drives both handshakes, gives the verdict.
// Depends on hrp_pkg, http_request_byte_parser and http_request_byte_parser_checker.
module tb_http_request_byte_parser;
	import hrp_pkg::*;

	localparam int BYTE_TARGET  = 1850;
	localparam int STALL_LIMIT  = 3000;
	localparam int LONG_HOLD    = 80;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         out_byte;
	logic [3:0]         role;
	logic               field_first;
	logic               drop_line;
	logic               final_res;
	logic [2:0]         status;
	logic               conn_persist;
	logic signed [31:0] req_length;
	logic [31:0]        body_length;
	int                 errors;
	int                 pending;

	bit        calm;        // no idling in the closing stretch
	bit        hold_req;    // asks the receiver for one long hold-off
	int        sent;
	int        quiet;
	byte       req_bytes[$];

	http_request_byte_parser u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .role(role), .field_first(field_first),
		.drop_line(drop_line), .final_res(final_res), .status(status),
		.conn_persist(conn_persist), .req_length(req_length),
		.body_length(body_length)
	);

	http_request_byte_parser_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .role(role), .field_first(field_first),
		.drop_line(drop_line), .final_res(final_res), .status(status),
		.conn_persist(conn_persist), .req_length(req_length),
		.body_length(body_length), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	// watchdog: any stretch without a beat on either side that runs too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else if (quiet >= STALL_LIMIT) begin
			$display("tb_http_request_byte_parser: errors");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// receiver: random stall bursts, one long hold-off on request, none at the end
	initial begin
		bit hold_done;
		hold_done = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_done = 1;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endtask

	task automatic add_random_word(int n);
		repeat (n)
			req_bytes.push_back(byte'($urandom_range("a", "z")));
	endtask

	// one beat; valid stays up from one item to the next unless a gap is drawn
	task automatic send_beat(byte b, bit fin);
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_request();
		foreach (req_bytes[i])
			send_beat(req_bytes[i], i == req_bytes.size() - 1);
		req_bytes.delete();
	endtask

	task automatic add_length_value();
		case ($urandom_range(0, 9))
			0: add_text("-1");
			1: add_text($sformatf("-%0d", $urandom_range(2, 9)));
			2: add_text($sformatf("+%0d", $urandom_range(0, 9)));
			3: add_text($sformatf("  %0dx", $urandom_range(0, 9)));
			4: add_text("");
			5: add_text("99999999999");
			6: add_text("-99999999999");
			7: add_text("12345678901234567890123456789012345");
			default: add_text($sformatf("%0d", $urandom_range(0, 12)));
		endcase
	endtask

	// mostly well-formed requests with random content
	task automatic build_request();
		int nh;
		case ($urandom_range(0, 2))
			0: add_text("GET");
			1: add_text("POST");
			default: add_random_word($urandom_range(1, 4));
		endcase
		add_text(" /");
		add_random_word($urandom_range(0, 4));
		if ($urandom_range(0, 2) == 0) begin
			add_text("?");
			add_random_word($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				add_text("?x");
		end
		if ($urandom_range(0, 9) == 0)
			add_text(" HTTP/");
		else
			add_text(" HTTP/1.1");
		add_text("\r\n");
		nh = $urandom_range(0, 4);
		repeat (nh) begin
			case ($urandom_range(0, 7))
				0, 1: begin
					add_text($urandom_range(0, 1) ? "Content-Length:" : "content-LENGTH:");
					if ($urandom_range(0, 1))
						add_text(" ");
					else
						add_text("\t ");
					add_length_value();
				end
				2: add_text("Connection: close");
				3: add_text("CONNECTION:\tClose");
				4: add_text("Connection: keep-alive");
				5: add_text("junkline");
				6: add_text("X-A: a\rb");
				default: begin
					add_random_word($urandom_range(1, 5));
					add_text(": ");
					add_random_word($urandom_range(0, 5));
				end
			endcase
			add_text("\r\n");
		end
		if ($urandom_range(0, 7) != 0)
			add_text("\r\n");
		repeat ($urandom_range(0, 10))
			req_bytes.push_back(byte'($urandom_range(0, 255)));
		// broken variants: cut short, or ending on a bare CR
		if ($urandom_range(0, 6) == 0)
			req_bytes = req_bytes[0:$urandom_range(0, req_bytes.size() - 1)];
		else if ($urandom_range(0, 9) == 0)
			req_bytes.push_back("\r");
	endtask

	initial begin
		int nreq;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		calm = 0;
		hold_req = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest good request with a query, a malformed line, extreme bytes
		add_text("G /?q HTTP/1.1\r\n\r\n");
		send_request();
		add_text("A B\r\n");
		req_bytes.push_back(8'hFF);
		req_bytes.push_back(8'h00);
		send_request();

		nreq = 0;
		while (sent < BYTE_TARGET) begin
			if (sent > BYTE_TARGET - 250)
				calm = 1;
			if (nreq == 3)
				hold_req = 1;
			if (nreq == 6) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending != 0 || out_valid);
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 20))
					req_bytes.push_back(byte'($urandom_range(0, 255)));
			end else
				build_request();
			send_request();
			nreq++;
		end
		in_valid <= 1'b0;
		last_byte <= 1'b0;
		do @(posedge clk); while (pending != 0 || out_valid);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_http_request_byte_parser: clean");
		else
			$display("tb_http_request_byte_parser: errors");
		$finish;
	end

endmodule
